/* sv/hgtl_pkg.sv */
`default_nettype none
package hgtl_pkg;

  localparam int HGT_W      = 16;
  localparam int POS_W      = 10;
  localparam int VIDX_W     = 23;
  localparam int GRID_CFG_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VERT_CNT_W = 3;

  localparam logic [VERT_CNT_W-1:0] VERTS_PER_SQUARE = 3'd6;
  localparam logic [VERT_CNT_W-1:0] VERT_LAST        = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIP = 2'd2;

  typedef struct packed {
    logic signed [HGT_W-1:0] height_sample;
    logic                    map_start;
  } hgtl_in_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos_x;
    logic signed [HGT_W-1:0] pos_y;
    logic [POS_W-1:0]        pos_z;
    logic                    tex_u;
    logic                    tex_v;
    logic [VIDX_W-1:0]       vertex_index;
    logic                    last;
    logic                    map_done;
  } hgtl_vertex_t;

  // one grid square waiting to be emitted
  typedef struct packed {
    logic [POS_W-1:0]  x_left;
    logic [POS_W-1:0]  x_right;
    logic [POS_W-1:0]  z_top;
    logic [POS_W-1:0]  z_bot;
    logic [HGT_W-1:0]  h_tl;
    logic [HGT_W-1:0]  h_tr;
    logic [HGT_W-1:0]  h_bl;
    logic [HGT_W-1:0]  h_br;
    logic              done;
    logic [VIDX_W-1:0] vbase;
  } hgtl_square_t;

endpackage
`default_nettype wire

/* sv/hgtl_channels.sv */
`default_nettype none
interface hgtl_in_if
  import hgtl_pkg::*;
();
  logic     valid;
  logic     ready;
  hgtl_in_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface hgtl_out_if
  import hgtl_pkg::*;
();
  logic         valid;
  logic         ready;
  hgtl_vertex_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/hgtl_ram.sv */
`default_nettype none
module hgtl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/heightmap_grid_to_triangle_list.sv */
// Height samples enter row-major, one transfer each. A sample that closes a grid square
// (not in the first row or column) yields six vertex transfers, so such samples wait on
// the result channel; others are taken one per cycle while the square buffer has room.
// The first vertex comes from the square buffer, after stage 1. The previous row lives
// in one MAX_WIDTH x 16 RAM (one write, one registered read per cycle); its contents are
// not cleared, so a map must begin with a full first row. Two squares can be buffered.
`default_nettype none
module heightmap_grid_to_triangle_list
  import hgtl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  hgtl_in_if.sink                    in_ch,
  hgtl_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WSW = CW + 1;
  localparam int HSW = RW + 1;
  localparam int WLW = (WSW > GRID_CFG_W) ? WSW : GRID_CFG_W;
  localparam int HLW = (HSW > GRID_CFG_W) ? HSW : GRID_CFG_W;

  // configuration
  logic [GRID_CFG_W-1:0] grid_width_r, grid_height_r;
  logic [HGT_W-1:0]      recip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 11'd1024;
      grid_height_r <= 11'd1024;
      recip_r       <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[GRID_CFG_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata[GRID_CFG_W-1:0];
        CFG_SCALE_RECIP: recip_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [WLW-1:0] gw_ext;
  logic [HLW-1:0] gh_ext;
  logic [WSW-1:0] eff_w;
  logic [HSW-1:0] eff_h;

  always_comb begin
    gw_ext = WLW'(grid_width_r);
    gh_ext = HLW'(grid_height_r);
    if (gw_ext < WLW'(2))                eff_w = WSW'(2);
    else if (gw_ext > WLW'(MAX_WIDTH))   eff_w = WSW'(MAX_WIDTH);
    else                                 eff_w = WSW'(gw_ext);
    if (gh_ext < HLW'(2))                eff_h = HSW'(2);
    else if (gh_ext > HLW'(MAX_HEIGHT))  eff_h = HSW'(MAX_HEIGHT);
    else                                 eff_h = HSW'(gh_ext);
  end

  // stage 0: counters, RAM read, multiply
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [VIDX_W-1:0] vc_r;

  logic              in_fire;
  logic [CW-1:0]     col0, col_nxt;
  logic [RW-1:0]     row0, row_nxt;
  logic [VIDX_W-1:0] vc0, vc_nxt;
  logic [WSW-1:0]    col_inc;
  logic [HSW-1:0]    row_inc;
  logic              in_range0, emit0, wrap_c, wrap_r, done0;
  logic signed [2*HGT_W:0] prod;

  always_comb begin
    col0      = in_ch.payload.map_start ? '0 : col_r;
    row0      = in_ch.payload.map_start ? '0 : row_r;
    vc0       = in_ch.payload.map_start ? '0 : vc_r;
    in_range0 = ({1'b0, col0} < eff_w) && ({1'b0, row0} < eff_h);
    emit0     = in_range0 && (col0 != '0) && (row0 != '0);
    done0     = ({1'b0, row0} == eff_h - HSW'(1)) && ({1'b0, col0} == eff_w - WSW'(1));
    col_inc   = {1'b0, col0} + WSW'(1);
    row_inc   = {1'b0, row0} + HSW'(1);
    wrap_c    = col_inc >= eff_w;
    wrap_r    = wrap_c && (row_inc >= eff_h);
    col_nxt   = wrap_c ? '0 : col_inc[CW-1:0];
    row_nxt   = wrap_c ? (wrap_r ? '0 : row_inc[RW-1:0]) : row0;
    if (wrap_r)     vc_nxt = '0;
    else if (emit0) vc_nxt = vc0 + VIDX_W'(VERTS_PER_SQUARE);
    else            vc_nxt = vc0;
    prod = in_ch.payload.height_sample * $signed({1'b0, recip_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      vc_r  <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      vc_r  <= vc_nxt;
    end
  end

  // stage 1: line buffer read data, scaled height, write-back
  logic                    s1_v_r, s1_inr_r, s1_emit_r, s1_fwd_r;
  logic [CW-1:0]           s1_col_r;
  logic signed [2*HGT_W-1:0] s1_prod_r;
  logic [HGT_W-1:0]        fwd_y_r;
  hgtl_square_t            s1_sq_r;
  logic [HGT_W-1:0]        diag_r, left_r;
  logic [HGT_W-1:0]        ram_rdata, up1, y1;
  logic signed [2*HGT_W:0] rsum;
  logic signed [HGT_W+8:0] q1;
  logic                    s1_new;
  hgtl_square_t            sq_new;

  always_comb begin
    rsum = {s1_prod_r[2*HGT_W-1], s1_prod_r} + 33'sd128;
    q1   = rsum[2*HGT_W:8];
    if (q1[HGT_W+8:HGT_W-1] == '0 || q1[HGT_W+8:HGT_W-1] == '1) y1 = q1[HGT_W-1:0];
    else if (q1[HGT_W+8])                                         y1 = 16'h8000;
    else                                                          y1 = 16'h7fff;
    up1    = s1_fwd_r ? fwd_y_r : ram_rdata;
    s1_new = s1_v_r && s1_emit_r;
    sq_new = s1_sq_r;
    sq_new.h_tl = diag_r;
    sq_new.h_tr = up1;
    sq_new.h_bl = left_r;
    sq_new.h_br = y1;
  end

  hgtl_ram #(
    .WIDTH (HGT_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_v_r && s1_inr_r),
    .waddr (s1_col_r),
    .wdata (y1),
    .raddr (col0),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      diag_r <= '0;
      left_r <= '0;
    end else begin
      s1_v_r <= in_fire;
      if (s1_v_r && s1_inr_r) begin
        diag_r <= up1;
        left_r <= y1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_inr_r        <= in_range0;
      s1_emit_r       <= emit0;
      s1_col_r        <= col0;
      s1_prod_r       <= (2*HGT_W)'(prod);
      s1_fwd_r        <= s1_v_r && s1_inr_r && (s1_col_r == col0);
      fwd_y_r         <= y1;
      s1_sq_r.x_left  <= POS_W'(col0 - CW'(1));
      s1_sq_r.x_right <= POS_W'(col0);
      s1_sq_r.z_top   <= POS_W'(eff_h - HSW'(row0));
      s1_sq_r.z_bot   <= POS_W'(eff_h - HSW'(1) - HSW'(row0));
      s1_sq_r.h_tl    <= '0;
      s1_sq_r.h_tr    <= '0;
      s1_sq_r.h_bl    <= '0;
      s1_sq_r.h_br    <= '0;
      s1_sq_r.done    <= done0;
      s1_sq_r.vbase   <= vc0;
    end
  end

  // square buffer and vertex emitter
  logic                  sq_v_r, pend_v_r;
  hgtl_square_t          sq_r, pend_r;
  logic [VERT_CNT_W-1:0] k_r;
  logic                  out_fire, sq_fin, sq_free;
  logic [1:0]            occupancy;

  always_comb begin
    out_fire  = sq_v_r && out_ch.ready;
    sq_fin    = out_fire && (k_r == VERT_LAST);
    sq_free   = !sq_v_r || sq_fin;
    occupancy = {1'b0, sq_v_r} + {1'b0, pend_v_r} + {1'b0, s1_new};
    in_ch.ready = occupancy < 2'd2;
    in_fire   = in_ch.valid && in_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      k_r      <= '0;
    end else begin
      if (out_fire) begin
        k_r <= sq_fin ? '0 : k_r + VERT_CNT_W'(1);
      end
      if (sq_free) begin
        if (pend_v_r) begin
          sq_v_r   <= 1'b1;
          pend_v_r <= s1_new;
        end else begin
          sq_v_r   <= s1_new;
        end
      end else if (s1_new) begin
        pend_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_free) begin
      if (pend_v_r) begin
        sq_r   <= pend_r;
        pend_r <= sq_new;
      end else begin
        sq_r   <= sq_new;
      end
    end else if (s1_new) begin
      pend_r <= sq_new;
    end
  end

  always_comb begin
    out_ch.valid                = sq_v_r;
    out_ch.payload.vertex_index = sq_r.vbase + VIDX_W'(k_r);
    out_ch.payload.last         = 1'b0;
    out_ch.payload.map_done     = 1'b0;
    case (k_r)
      3'd0: begin
        out_ch.payload.pos_x = sq_r.x_left;
        out_ch.payload.pos_y = sq_r.h_tl;
        out_ch.payload.pos_z = sq_r.z_top;
        out_ch.payload.tex_u = 1'b0;
        out_ch.payload.tex_v = 1'b0;
      end
      3'd1, 3'd4: begin
        out_ch.payload.pos_x = sq_r.x_right;
        out_ch.payload.pos_y = sq_r.h_tr;
        out_ch.payload.pos_z = sq_r.z_top;
        out_ch.payload.tex_u = 1'b1;
        out_ch.payload.tex_v = 1'b0;
      end
      3'd2, 3'd3: begin
        out_ch.payload.pos_x = sq_r.x_left;
        out_ch.payload.pos_y = sq_r.h_bl;
        out_ch.payload.pos_z = sq_r.z_bot;
        out_ch.payload.tex_u = 1'b0;
        out_ch.payload.tex_v = 1'b1;
      end
      default: begin
        out_ch.payload.pos_x    = sq_r.x_right;
        out_ch.payload.pos_y    = sq_r.h_br;
        out_ch.payload.pos_z    = sq_r.z_bot;
        out_ch.payload.tex_u    = 1'b1;
        out_ch.payload.tex_v    = 1'b1;
        out_ch.payload.last     = 1'b1;
        out_ch.payload.map_done = sq_r.done;
      end
    endcase
  end

  a_pend_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_v_r && !sq_free && s1_new))
    else $error("square buffer overrun");

  a_square_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !sq_fin) |=> sq_v_r)
    else $error("square ended before sixth vertex");

  a_stage1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted sample lost before line buffer stage");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_v_r && out_ch.payload.map_done) |-> out_ch.payload.last)
    else $error("map_done without last");

endmodule
`default_nettype wire
